FILE: src/tskh_pkg.sv
`default_nettype none

package tskh_pkg;

	localparam int KIND_W  = 4;
	localparam int KEY_W   = 64;
	localparam int HASH_W  = 64;
	localparam int NBYTE_W = 4;

	// key kind codes
	localparam logic [KIND_W-1:0] KIND_S8    = 4'd0;
	localparam logic [KIND_W-1:0] KIND_S16   = 4'd1;
	localparam logic [KIND_W-1:0] KIND_S32   = 4'd2;
	localparam logic [KIND_W-1:0] KIND_S64   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_U8    = 4'd4;
	localparam logic [KIND_W-1:0] KIND_U16   = 4'd5;
	localparam logic [KIND_W-1:0] KIND_U32   = 4'd6;
	localparam logic [KIND_W-1:0] KIND_U64   = 4'd7;
	localparam logic [KIND_W-1:0] KIND_USIZE = 4'd8;
	localparam logic [KIND_W-1:0] KIND_F32   = 4'd9;
	localparam logic [KIND_W-1:0] KIND_F64   = 4'd10;
	localparam logic [KIND_W-1:0] KIND_BOOL  = 4'd11;
	localparam logic [KIND_W-1:0] KIND_PTR   = 4'd12;

	// fixed hash codes
	localparam logic [HASH_W-1:0] HASH_TRUE    = 64'd1231;
	localparam logic [HASH_W-1:0] HASH_FALSE   = 64'd1237;
	localparam logic [HASH_W-1:0] HASH_POS_INF = ~64'd0;
	localparam logic [HASH_W-1:0] HASH_NEG_INF = ~64'd1;
	localparam logic [HASH_W-1:0] HASH_NAN     = ~64'd2;
	localparam logic [HASH_W-1:0] HASH_ZERO    = 64'd0;

	// fold round constants
	localparam int FOLD_SHL = 5;
	localparam int FOLD_SHR = 2;

	// decode result: fold nbytes of the key, or take the fixed code
	typedef struct packed {
		logic               use_fold;
		logic [NBYTE_W-1:0] nbytes;
		logic [HASH_W-1:0]  fixed;
	} key_sel_t;

endpackage

`default_nettype wire

FILE: src/tskh_key_if.sv
`default_nettype none

interface tskh_key_if;
	logic                        valid;
	logic                        ready;
	logic [tskh_pkg::KIND_W-1:0] key_kind;
	logic [tskh_pkg::KEY_W-1:0]  key_value;

	modport source (output valid, key_kind, key_value, input ready);
	modport sink   (input valid, key_kind, key_value, output ready);
endinterface

`default_nettype wire

FILE: src/tskh_hash_if.sv
`default_nettype none

interface tskh_hash_if;
	logic                        valid;
	logic                        ready;
	logic [tskh_pkg::HASH_W-1:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

FILE: src/tskh_decode.sv
`default_nettype none

module tskh_decode (
	input  wire logic [tskh_pkg::KIND_W-1:0] key_kind,
	input  wire logic [tskh_pkg::KEY_W-1:0]  key_value,
	output tskh_pkg::key_sel_t               sel
);

	logic [7:0]  f32_exp;
	logic [22:0] f32_mant;
	logic [10:0] f64_exp;
	logic [51:0] f64_mant;

	assign f32_exp  = key_value[30:23];
	assign f32_mant = key_value[22:0];
	assign f64_exp  = key_value[62:52];
	assign f64_mant = key_value[51:0];

	always_comb begin
		sel.use_fold = 1'b0;
		sel.nbytes   = 4'd0;
		sel.fixed    = tskh_pkg::HASH_ZERO;
		unique case (key_kind)
			tskh_pkg::KIND_S8, tskh_pkg::KIND_U8: begin
				sel.use_fold = 1'b1;
				sel.nbytes   = 4'd1;
			end
			tskh_pkg::KIND_S16, tskh_pkg::KIND_U16: begin
				sel.use_fold = 1'b1;
				sel.nbytes   = 4'd2;
			end
			tskh_pkg::KIND_S32, tskh_pkg::KIND_U32: begin
				sel.use_fold = 1'b1;
				sel.nbytes   = 4'd4;
			end
			tskh_pkg::KIND_S64, tskh_pkg::KIND_U64, tskh_pkg::KIND_USIZE: begin
				sel.use_fold = 1'b1;
				sel.nbytes   = 4'd8;
			end
			tskh_pkg::KIND_F32: begin
				sel.nbytes = 4'd4;
				if (f32_exp == 8'hFF) begin
					if (f32_mant == 23'd0) begin
						sel.fixed = key_value[31] ? tskh_pkg::HASH_NEG_INF
						                          : tskh_pkg::HASH_POS_INF;
					end else begin
						sel.fixed = tskh_pkg::HASH_NAN;
					end
				end else if (f32_exp == 8'd0 && f32_mant == 23'd0) begin
					sel.fixed = tskh_pkg::HASH_ZERO;
				end else begin
					sel.use_fold = 1'b1;
				end
			end
			tskh_pkg::KIND_F64: begin
				sel.nbytes = 4'd8;
				if (f64_exp == 11'h7FF) begin
					if (f64_mant == 52'd0) begin
						sel.fixed = key_value[63] ? tskh_pkg::HASH_NEG_INF
						                          : tskh_pkg::HASH_POS_INF;
					end else begin
						sel.fixed = tskh_pkg::HASH_NAN;
					end
				end else if (f64_exp == 11'd0 && f64_mant == 52'd0) begin
					sel.fixed = tskh_pkg::HASH_ZERO;
				end else begin
					sel.use_fold = 1'b1;
				end
			end
			tskh_pkg::KIND_BOOL: begin
				sel.fixed = (key_value != 64'd0) ? tskh_pkg::HASH_TRUE
				                                 : tskh_pkg::HASH_FALSE;
			end
			tskh_pkg::KIND_PTR: begin
				sel.fixed = key_value;
			end
			default: begin
				// undefined kinds hash to zero
				sel.fixed = tskh_pkg::HASH_ZERO;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/tskh_fold.sv
`default_nettype none

// Byte fold, most significant used byte first; rounds past nbytes pass h along.
module tskh_fold (
	input  wire logic [tskh_pkg::KEY_W-1:0]   key_value,
	input  wire logic [tskh_pkg::NBYTE_W-1:0] nbytes,
	output logic      [tskh_pkg::HASH_W-1:0]  hash_value
);

	localparam int ROUNDS = tskh_pkg::KEY_W / 8;

	always_comb begin
		logic [tskh_pkg::HASH_W-1:0]  h;
		logic [tskh_pkg::NBYTE_W-1:0] pos;
		logic [7:0]                   b;
		h = {{(tskh_pkg::HASH_W-tskh_pkg::NBYTE_W){1'b0}}, nbytes};
		for (int j = 0; j < ROUNDS; j++) begin
			pos = nbytes - tskh_pkg::NBYTE_W'(j) - tskh_pkg::NBYTE_W'(1);
			b   = key_value[{pos[2:0], 3'b000} +: 8];
			if (tskh_pkg::NBYTE_W'(j) < nbytes) begin
				h = h ^ ((h << tskh_pkg::FOLD_SHL) + (h >> tskh_pkg::FOLD_SHR)
				         + {{(tskh_pkg::HASH_W-8){1'b0}}, b});
			end
		end
		hash_value = h;
	end

endmodule

`default_nettype wire

FILE: src/typed_scalar_key_hash.sv
`default_nettype none

// Channel   | Dir | Payload                          | Handshake
// ----------+-----+----------------------------------+------------
// key_in    | in  | key_kind[3:0], key_value[63:0]   | valid/ready
// hash_out  | out | hash_value[63:0]                 | valid/ready
//
// One key per cycle sustained while hash_out takes results; an accepted key is held in
// the stage 1 register and then its hash in the stage 2 register, which drives hash_out.
// Stage 1 is the input register; decode and the eight-round byte fold sit between
// it and the stage 2 result register, and set the clock period.
// arst_n clears only the valid bits; payload registers are not reset.
// A stalled result holds in stage 2 while stage 1 still takes a key; key_in.ready
// drops only when both stages are full and hash_out is stalled.
module typed_scalar_key_hash (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tskh_key_if.sink    key_in,
	tskh_hash_if.source hash_out
);

	logic                        valid_s1;
	logic [tskh_pkg::KIND_W-1:0] kind_s1;
	logic [tskh_pkg::KEY_W-1:0]  value_s1;
	logic                        valid_s2;
	logic [tskh_pkg::HASH_W-1:0] hash_s2;

	logic                        ready_s2;
	tskh_pkg::key_sel_t          sel;
	logic [tskh_pkg::HASH_W-1:0] fold_hash;
	logic [tskh_pkg::HASH_W-1:0] result;

	// stage 2 frees up when empty or when its item leaves this cycle
	assign ready_s2     = !valid_s2 || hash_out.ready;
	assign key_in.ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.valid && key_in.ready) begin
			kind_s1  <= key_in.key_kind;
			value_s1 <= key_in.key_value;
		end
	end

	tskh_decode u_decode (
		.key_kind  (kind_s1),
		.key_value (value_s1),
		.sel       (sel)
	);

	tskh_fold u_fold (
		.key_value  (value_s1),
		.nbytes     (sel.nbytes),
		.hash_value (fold_hash)
	);

	assign result = sel.use_fold ? fold_hash : sel.fixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			hash_s2 <= result;
		end
	end

	assign hash_out.valid      = valid_s2;
	assign hash_out.hash_value = hash_s2;

	// an item moving out of stage 1 lands in stage 2
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 |=> valid_s2)
		else $error("stage 1 item lost on its way to stage 2");

	// a blocked stage 1 keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(value_s1) && $stable(kind_s1))
		else $error("stage 1 item overwritten while blocked");

	// pointers pass through unchanged
	a_ptr_pass: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 && kind_s1 == tskh_pkg::KIND_PTR
		|=> hash_s2 == $past(value_s1))
		else $error("pointer key not passed through");

	// booleans give one of the two fixed codes
	a_bool_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 && kind_s1 == tskh_pkg::KIND_BOOL
		|=> hash_s2 == tskh_pkg::HASH_TRUE || hash_s2 == tskh_pkg::HASH_FALSE)
		else $error("boolean key gave an unexpected hash");

endmodule

`default_nettype wire
